@@ hdl/mptd_pkg.sv @@
package mptd_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [8:0] TABLE_OFFSET = 9'h1BE;
  localparam logic [8:0] TABLE_END = 9'h1FE;
  localparam logic [8:0] SIG_POS_LOW = 9'd510;
  localparam logic [8:0] SIG_POS_HIGH = 9'd511;
  localparam logic [7:0] SIG_LOW = 8'h55;
  localparam logic [7:0] SIG_HIGH = 8'hAA;
  localparam logic [7:0] TYPE_GPT = 8'hEE;
  localparam logic [7:0] BOOT_MARK = 8'h80;
  localparam int SECTOR_SHIFT = 9;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIG = 2'd2;
  localparam logic [1:0] STATUS_GPT = 2'd3;

  localparam logic [2:0] CLASS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLASS_LINUX = 3'd1;
  localparam logic [2:0] CLASS_NTFS = 3'd2;
  localparam logic [2:0] CLASS_FAT32 = 3'd3;
  localparam logic [2:0] CLASS_FAT16 = 3'd4;
  localparam logic [2:0] CLASS_SWAP = 3'd5;

  localparam logic [7:0] TYPE_LINUX = 8'h83;
  localparam logic [7:0] TYPE_NTFS = 8'h07;
  localparam logic [7:0] TYPE_FAT32 = 8'h0B;
  localparam logic [7:0] TYPE_FAT32_LBA = 8'h0C;
  localparam logic [7:0] TYPE_FAT12 = 8'h01;
  localparam logic [7:0] TYPE_FAT16_SMALL = 8'h04;
  localparam logic [7:0] TYPE_FAT16 = 8'h06;
  localparam logic [7:0] TYPE_FAT16_LBA = 8'h0E;
  localparam logic [7:0] TYPE_SWAP = 8'h82;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       sector_start;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic        bootable;
    logic [7:0]  type_code;
    logic [2:0]  type_class;
    logic [31:0] start_lba;
    logic [31:0] sector_count;
    logic [40:0] start_byte;
    logic [40:0] size_bytes;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        boot;
    logic [7:0]  type_code;
    logic [31:0] start_lba;
    logic [31:0] sector_count;
  } entry_t;

  typedef struct packed {
    logic                        sig_ok;
    entry_t [SLOT_COUNT-1:0]     entries;
  } job_t;

  function automatic logic [2:0] type_class_of(input logic [7:0] t);
    logic [2:0] c;
    case (t)
      TYPE_LINUX: c = CLASS_LINUX;
      TYPE_NTFS: c = CLASS_NTFS;
      TYPE_FAT32, TYPE_FAT32_LBA: c = CLASS_FAT32;
      TYPE_FAT12, TYPE_FAT16_SMALL, TYPE_FAT16, TYPE_FAT16_LBA: c = CLASS_FAT16;
      TYPE_SWAP: c = CLASS_SWAP;
      default: c = CLASS_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic out_item_t make_status(input logic [1:0] code);
    out_item_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = code;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_item_t make_entry(input logic [2:0] slot, input entry_t e);
    out_item_t r;
    r.kind = KIND_ENTRY;
    r.slot = slot;
    r.bootable = e.boot;
    r.type_code = e.type_code;
    r.type_class = type_class_of(e.type_code);
    r.start_lba = e.start_lba;
    r.sector_count = e.sector_count;
    r.start_byte = {e.start_lba, {SECTOR_SHIFT{1'b0}}};
    r.size_bytes = {e.sector_count, {SECTOR_SHIFT{1'b0}}};
    r.status = STATUS_FOUND;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

@@ hdl/mptd_front.sv @@
module mptd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mptd_pkg::in_item_t item,
  output logic              push,
  output mptd_pkg::job_t    job
);

  logic [8:0] byte_position;
  logic [8:0] pos;
  logic [8:0] rel;
  logic       in_table;
  logic [1:0] s;
  logic [3:0] off;
  logic       signature_low_seen;
  mptd_pkg::entry_t ent [mptd_pkg::SLOT_COUNT];

  assign pos = item.sector_start ? 9'd0 : byte_position;
  assign rel = pos - mptd_pkg::TABLE_OFFSET;
  assign in_table = (pos >= mptd_pkg::TABLE_OFFSET) && (pos < mptd_pkg::TABLE_END);
  assign s = rel[5:4];
  assign off = rel[3:0];

  assign push = accept && (pos == mptd_pkg::SIG_POS_HIGH);

  always_comb begin
    job.sig_ok = signature_low_seen && (item.byte_value == mptd_pkg::SIG_HIGH);
    for (int i = 0; i < mptd_pkg::SLOT_COUNT; i++) begin
      job.entries[i] = ent[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      signature_low_seen <= 1'b0;
    end else if (accept) begin
      byte_position <= pos + 9'd1;
      if (pos == mptd_pkg::SIG_POS_LOW) begin
        signature_low_seen <= (item.byte_value == mptd_pkg::SIG_LOW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_table) begin
      case (off[3:2])
        2'b00: begin
          if (off[1:0] == 2'd0) begin
            ent[s].boot <= (item.byte_value == mptd_pkg::BOOT_MARK);
          end
        end
        2'b01: begin
          if (off[1:0] == 2'd0) begin
            ent[s].type_code <= item.byte_value;
          end
        end
        2'b10: ent[s].start_lba[8*off[1:0] +: 8] <= item.byte_value;
        default: ent[s].sector_count[8*off[1:0] +: 8] <= item.byte_value;
      endcase
    end
  end

endmodule

@@ hdl/mptd_queue.sv @@
module mptd_queue #(
  parameter int DEPTH = mptd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mptd_pkg::job_t wr_job,
  output logic           full,
  output logic           head_valid,
  output mptd_pkg::job_t head,
  input  logic           pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mptd_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/mptd_back.sv @@
module mptd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  mptd_pkg::job_t      head,
  output logic                pop,
  output logic                record_valid,
  input  logic                record_ready,
  output mptd_pkg::out_item_t record
);

  localparam logic [2:0] IDX_DONE = 3'(mptd_pkg::SLOT_COUNT);

  logic [2:0]       idx;
  logic             found;
  logic             adv;
  logic             used;
  logic             gpt;
  mptd_pkg::entry_t cur;

  assign adv = head_valid && (!record_valid || record_ready);
  assign cur = head.entries[idx[1:0]];
  assign used = (cur.type_code != 8'd0) && (cur.sector_count != 32'd0);
  assign gpt = (cur.type_code == mptd_pkg::TYPE_GPT);
  assign pop = adv && (!head.sig_ok || (idx == IDX_DONE) || (used && gpt));

  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
      idx <= '0;
      found <= 1'b0;
    end else begin
      if (adv) begin
        if (!head.sig_ok) begin
          record <= mptd_pkg::make_status(mptd_pkg::STATUS_BAD_SIG);
          record_valid <= 1'b1;
          idx <= '0;
          found <= 1'b0;
        end else if (idx == IDX_DONE) begin
          record <= mptd_pkg::make_status(found ? mptd_pkg::STATUS_FOUND
                                                : mptd_pkg::STATUS_NONE);
          record_valid <= 1'b1;
          idx <= '0;
          found <= 1'b0;
        end else if (used && gpt) begin
          record <= mptd_pkg::make_status(mptd_pkg::STATUS_GPT);
          record_valid <= 1'b1;
          idx <= '0;
          found <= 1'b0;
        end else begin
          if (used) begin
            record <= mptd_pkg::make_entry(idx + 3'd1, cur);
            found <= 1'b1;
          end
          record_valid <= used;
          idx <= idx + 3'd1;
        end
      end else if (record_ready) begin
        record_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/mbr_partition_table_decoder_unit.sv @@
// MBR partition table decoder. Sector bytes are taken one per cycle; sector_ready
// falls only while the job queue holds QUEUE_DEPTH sector snapshots that still
// await decoding. On byte 511 the front end pushes a snapshot of the four entries
// and the signature check into the queue; the back end then scans the slots and
// emits entry items in slot order followed by one status item with last set.
module mbr_partition_table_decoder_unit #(
  parameter int QUEUE_DEPTH = mptd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sector_valid,
  output logic                sector_ready,
  input  mptd_pkg::in_item_t  sector_byte,
  output logic                record_valid,
  input  logic                record_ready,
  output mptd_pkg::out_item_t record
);

  logic           accept;
  logic           push;
  logic           full;
  logic           head_valid;
  logic           pop;
  mptd_pkg::job_t wr_job;
  mptd_pkg::job_t head;

  assign sector_ready = !full;
  assign accept = sector_valid && sector_ready;

  mptd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (sector_byte),
    .push   (push),
    .job    (wr_job)
  );

  mptd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_job     (wr_job),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  mptd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record       (record)
  );

endmodule

@@ hdl/mptd_checker.sv @@
module mptd_checker (
  input logic                clk,
  input logic                rst,
  input logic                record_valid,
  input logic                record_ready,
  input mptd_pkg::out_item_t record
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    record_valid && !record_ready |=> record_valid && $stable(record))
    else $error("record dropped or changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    record_valid |-> (record.last == (record.kind == mptd_pkg::KIND_STATUS)))
    else $error("last does not mark the status item");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    record_valid && record.kind == mptd_pkg::KIND_ENTRY |->
      record.slot != 3'd0 && record.sector_count != 32'd0 &&
      record.type_code != 8'd0 && record.type_code != mptd_pkg::TYPE_GPT &&
      record.size_bytes == {record.sector_count, 9'd0})
    else $error("entry item malformed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    record_valid && record.kind == mptd_pkg::KIND_STATUS |->
      record.slot == 3'd0 && record.start_byte == 41'd0)
    else $error("status item carries entry fields");

endmodule

bind mbr_partition_table_decoder_unit mptd_checker u_chk (.*);

@@ test/mbr_record_checker.sv @@
module mbr_record_checker
  import mptd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      sector_valid,
  input  logic      sector_ready,
  input  in_item_t  sector_byte,
  input  logic      record_valid,
  input  logic      record_ready,
  input  out_item_t record,
  output int        mismatches,
  output int        pending
);

  localparam int REPORT_LIMIT = 40;
  localparam logic [7:0] TYPE_EMPTY = 8'h00;

  logic [8:0]  next_pos;
  logic        boot_flag [SLOT_COUNT];
  logic [7:0]  part_type [SLOT_COUNT];
  logic [31:0] first_lba [SLOT_COUNT];
  logic [31:0] part_len  [SLOT_COUNT];
  logic        sig_low_ok;
  out_item_t   expected_records [$];

  function automatic logic [2:0] class_of(input logic [7:0] code);
    case (code)
      TYPE_LINUX: return CLASS_LINUX;
      TYPE_NTFS: return CLASS_NTFS;
      TYPE_FAT32, TYPE_FAT32_LBA: return CLASS_FAT32;
      TYPE_FAT12, TYPE_FAT16_SMALL, TYPE_FAT16, TYPE_FAT16_LBA: return CLASS_FAT16;
      TYPE_SWAP: return CLASS_SWAP;
      default: return CLASS_UNKNOWN;
    endcase
  endfunction

  function automatic out_item_t status_record(input logic [1:0] code);
    out_item_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = code;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_item_t entry_record(input int s);
    out_item_t r;
    r = '0;
    r.kind = KIND_ENTRY;
    r.slot = 3'(s + 1);
    r.bootable = boot_flag[s];
    r.type_code = part_type[s];
    r.type_class = class_of(part_type[s]);
    r.start_lba = first_lba[s];
    r.sector_count = part_len[s];
    r.start_byte = 41'(first_lba[s]) << SECTOR_SHIFT;
    r.size_bytes = 41'(part_len[s]) << SECTOR_SHIFT;
    return r;
  endfunction

  task automatic decode_sector_byte(input in_item_t it);
    logic [8:0] pos;
    logic [5:0] rel;
    logic [1:0] s;
    logic [3:0] off;
    bit         found;
    bit         gpt_hit;
    pos = it.sector_start ? 9'd0 : next_pos;
    next_pos = pos + 9'd1;
    rel = 6'(pos - TABLE_OFFSET);
    s = rel[5:4];
    off = rel[3:0];
    found = 1'b0;
    gpt_hit = 1'b0;
    if (pos >= TABLE_OFFSET && pos < TABLE_END) begin
      if (off == 4'd0) begin
        boot_flag[s] = (it.byte_value == BOOT_MARK);
      end else if (off == 4'd4) begin
        part_type[s] = it.byte_value;
      end else if (off >= 4'd8 && off < 4'd12) begin
        first_lba[s][8*(off-4'd8) +: 8] = it.byte_value;
      end else if (off >= 4'd12) begin
        part_len[s][8*(off-4'd12) +: 8] = it.byte_value;
      end
    end else if (pos == SIG_POS_LOW) begin
      sig_low_ok = (it.byte_value == SIG_LOW);
    end else if (pos == SIG_POS_HIGH) begin
      if (!(sig_low_ok && it.byte_value == SIG_HIGH)) begin
        expected_records.push_back(status_record(STATUS_BAD_SIG));
      end else begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!gpt_hit && part_type[i] != TYPE_EMPTY && part_len[i] != 32'd0) begin
            if (part_type[i] == TYPE_GPT) begin
              gpt_hit = 1'b1;
            end else begin
              expected_records.push_back(entry_record(i));
              found = 1'b1;
            end
          end
        end
        if (gpt_hit) begin
          expected_records.push_back(status_record(STATUS_GPT));
        end else begin
          expected_records.push_back(status_record(found ? STATUS_FOUND : STATUS_NONE));
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [40:0] want, input logic [40:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT) begin
        $display("%0t: record %s mismatch, expected %0h got %0h", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  task automatic compare_record(input out_item_t got);
    out_item_t want;
    if (expected_records.size() == 0) begin
      if (mismatches < REPORT_LIMIT) begin
        $display("%0t: unexpected record, expected none got %0h", $time, got);
      end
      mismatches++;
    end else begin
      want = expected_records.pop_front();
      check_field("kind", 41'(want.kind), 41'(got.kind));
      check_field("slot", 41'(want.slot), 41'(got.slot));
      check_field("bootable", 41'(want.bootable), 41'(got.bootable));
      check_field("type_code", 41'(want.type_code), 41'(got.type_code));
      check_field("type_class", 41'(want.type_class), 41'(got.type_class));
      check_field("start_lba", 41'(want.start_lba), 41'(got.start_lba));
      check_field("sector_count", 41'(want.sector_count), 41'(got.sector_count));
      check_field("start_byte", want.start_byte, got.start_byte);
      check_field("size_bytes", want.size_bytes, got.size_bytes);
      check_field("status", 41'(want.status), 41'(got.status));
      check_field("last", 41'(want.last), 41'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      next_pos = 9'd0;
      sig_low_ok = 1'b0;
      mismatches = 0;
      expected_records.delete();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        boot_flag[i] = 1'b0;
        part_type[i] = TYPE_EMPTY;
        first_lba[i] = 32'd0;
        part_len[i] = 32'd0;
      end
    end else begin
      if (sector_valid && sector_ready) decode_sector_byte(sector_byte);
      if (record_valid && record_ready) compare_record(record);
    end
    pending = expected_records.size();
  end

endmodule

@@ test/tb_mbr_partition_table_decoder_unit.sv @@
module tb_mbr_partition_table_decoder_unit;
  import mptd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2500;
  localparam int DRAIN_CYCLES = 16;
  localparam int SECTOR_BYTES = 512;
  localparam int ENTRY_BYTES = 16;
  localparam int SECTORS_PER_PHASE = 10;
  localparam int PRESSURE_SECTORS = 4;
  localparam logic [7:0] TYPE_EMPTY = 8'h00;

  logic      clk;
  logic      rst;
  logic      sector_valid;
  logic      sector_ready;
  in_item_t  sector_byte;
  logic      record_valid;
  logic      record_ready;
  out_item_t record;

  int   mismatches;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  bit   hold_req;
  bit   hold_done;
  logic [7:0] sector_img [SECTOR_BYTES];
  logic [7:0] known_types [10];

  mbr_partition_table_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .sector_valid(sector_valid),
    .sector_ready(sector_ready),
    .sector_byte(sector_byte),
    .record_valid(record_valid),
    .record_ready(record_ready),
    .record(record)
  );

  mbr_record_checker record_check (
    .clk(clk),
    .rst(rst),
    .sector_valid(sector_valid),
    .sector_ready(sector_ready),
    .sector_byte(sector_byte),
    .record_valid(record_valid),
    .record_ready(record_ready),
    .record(record),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (sector_valid && sector_ready) || (record_valid && record_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // hold off once for a long stretch so the decoder fills up and stalls its input
  initial begin
    record_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !hold_done) begin
        record_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      record_ready <= ($urandom_range(99) >= stall_pct);
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      sector_valid <= 1'b0;
      @(posedge clk);
    end
    sector_valid <= 1'b1;
    sector_byte <= '{byte_value: value, sector_start: start};
    do @(posedge clk); while (!sector_ready);
  endtask

  task automatic stream_sector(input int n_bytes, input logic mark_start);
    for (int i = 0; i < n_bytes; i++) send_byte(sector_img[i], mark_start && i == 0);
  endtask

  task automatic fill_sector();
    for (int i = 0; i < SECTOR_BYTES; i++) sector_img[i] = 8'($urandom);
    sector_img[SIG_POS_LOW] = SIG_LOW;
    sector_img[SIG_POS_HIGH] = SIG_HIGH;
  endtask

  task automatic set_entry(input int slot, input logic [7:0] boot, input logic [7:0] code,
                           input logic [31:0] lba, input logic [31:0] len);
    int base;
    base = TABLE_OFFSET + ENTRY_BYTES * slot;
    sector_img[base] = boot;
    sector_img[base + 4] = code;
    for (int k = 0; k < 4; k++) begin
      sector_img[base + 8 + k] = lba[8*k +: 8];
      sector_img[base + 12 + k] = len[8*k +: 8];
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0, 1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      3, 4, 5: return 32'($urandom_range(1, 65535));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(19);
    if (r < 3) return TYPE_EMPTY;
    if (r == 3) return TYPE_GPT;
    if (r < 16) return known_types[$urandom_range(9)];
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_boot();
    case ($urandom_range(3))
      0, 1: return BOOT_MARK;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_sector();
    fill_sector();
    for (int s = 0; s < SLOT_COUNT; s++) set_entry(s, pick_boot(), pick_type(), pick_word(), pick_word());
    case ($urandom_range(19))
      0: sector_img[SIG_POS_LOW] ^= 8'($urandom_range(1, 255));
      1: sector_img[SIG_POS_HIGH] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
  endtask

  // occasionally cut a sector short and resync into a fresh one
  task automatic random_run();
    bit resync;
    resync = ($urandom_range(6) == 0);
    if (resync) begin
      random_sector();
      stream_sector($urandom_range(1, SECTOR_BYTES - 1), 1'($urandom_range(1)));
    end
    random_sector();
    stream_sector(SECTOR_BYTES, resync || $urandom_range(1));
  endtask

  initial begin
    rst <= 1'b1;
    sector_valid <= 1'b0;
    sector_byte <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    known_types = '{TYPE_LINUX, TYPE_NTFS, TYPE_FAT32, TYPE_FAT32_LBA, TYPE_FAT12,
                    TYPE_FAT16_SMALL, TYPE_FAT16, TYPE_FAT16_LBA, TYPE_SWAP, TYPE_GPT};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    fill_sector();
    set_entry(0, BOOT_MARK, TYPE_LINUX, 32'd0, 32'hFFFF_FFFF);
    set_entry(1, 8'h00, TYPE_NTFS, 32'hFFFF_FFFF, 32'd1);
    set_entry(2, BOOT_MARK, TYPE_FAT32, 32'd2048, 32'd4096);
    set_entry(3, 8'h7F, TYPE_SWAP, 32'd1, 32'h8000_0000);
    stream_sector(SECTOR_BYTES, 1'b1);

    // continue without a start mark: the position wraps on its own
    fill_sector();
    set_entry(0, 8'h81, TYPE_FAT12, 32'h0000_00FF, 32'h1234_5678);
    set_entry(1, BOOT_MARK, TYPE_FAT16_SMALL, 32'hFF00_0000, 32'hFFFF_FFFE);
    set_entry(2, 8'hFF, TYPE_FAT16, 32'h00FF_FF00, 32'd7);
    set_entry(3, 8'h00, TYPE_FAT16_LBA, 32'hDEAD_BEEF, 32'h0000_0100);
    stream_sector(SECTOR_BYTES, 1'b0);

    fill_sector();
    set_entry(0, BOOT_MARK, TYPE_FAT32_LBA, 32'd63, 32'd1);
    set_entry(1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_entry(2, 8'h00, 8'h05, 32'd100, 32'd200);
    set_entry(3, 8'h01, 8'h81, 32'd5, 32'd6);
    stream_sector(SECTOR_BYTES, 1'b1);

    fill_sector();
    set_entry(0, BOOT_MARK, TYPE_EMPTY, 32'd1, 32'd100);
    set_entry(1, BOOT_MARK, TYPE_LINUX, 32'd1, 32'd0);
    set_entry(2, 8'h00, TYPE_GPT, 32'd1, 32'd0);
    set_entry(3, 8'h00, TYPE_EMPTY, 32'd0, 32'd0);
    stream_sector(SECTOR_BYTES, 1'b1);

    fill_sector();
    set_entry(0, 8'h00, TYPE_GPT, 32'd1, 32'hFFFF_FFFF);
    set_entry(1, BOOT_MARK, TYPE_LINUX, 32'd2048, 32'd2048);
    set_entry(2, BOOT_MARK, TYPE_NTFS, 32'd4096, 32'd2048);
    set_entry(3, BOOT_MARK, TYPE_SWAP, 32'd8192, 32'd2048);
    stream_sector(SECTOR_BYTES, 1'b1);

    fill_sector();
    set_entry(0, BOOT_MARK, TYPE_LINUX, 32'd2048, 32'd10);
    set_entry(1, 8'h00, TYPE_NTFS, 32'd4096, 32'd20);
    set_entry(2, 8'h00, TYPE_GPT, 32'd1, 32'd30);
    set_entry(3, 8'h00, TYPE_FAT32, 32'd8192, 32'd40);
    stream_sector(SECTOR_BYTES, 1'b1);

    fill_sector();
    set_entry(0, 8'h00, TYPE_GPT, 32'd1, 32'd0);
    set_entry(1, BOOT_MARK, TYPE_LINUX, 32'd2048, 32'd99);
    set_entry(2, 8'h00, TYPE_EMPTY, 32'd5, 32'd5);
    set_entry(3, 8'h00, TYPE_GPT, 32'd1, 32'd1);
    stream_sector(SECTOR_BYTES, 1'b1);

    fill_sector();
    set_entry(0, BOOT_MARK, TYPE_LINUX, 32'd1, 32'd1);
    sector_img[SIG_POS_LOW] = 8'h54;
    stream_sector(SECTOR_BYTES, 1'b1);

    fill_sector();
    set_entry(0, BOOT_MARK, TYPE_LINUX, 32'd1, 32'd1);
    sector_img[SIG_POS_HIGH] = 8'hAB;
    stream_sector(SECTOR_BYTES, 1'b1);

    fill_sector();
    sector_img[SIG_POS_LOW] = SIG_HIGH;
    sector_img[SIG_POS_HIGH] = SIG_LOW;
    stream_sector(SECTOR_BYTES, 1'b1);

    // break off inside the table, then start over
    random_sector();
    stream_sector(470, 1'b1);
    fill_sector();
    set_entry(0, 8'h00, TYPE_EMPTY, 32'd0, 32'd0);
    set_entry(1, BOOT_MARK, TYPE_FAT16, 32'd77, 32'd88);
    set_entry(2, 8'h00, TYPE_EMPTY, 32'd0, 32'd0);
    set_entry(3, 8'h00, TYPE_LINUX, 32'd1000, 32'd2000);
    stream_sector(SECTOR_BYTES, 1'b1);

    hold_req = 1'b1;
    for (int k = 0; k < PRESSURE_SECTORS; k++) begin
      random_sector();
      stream_sector(SECTOR_BYTES, 1'b1);
    end
    hold_req = 1'b0;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 60;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 60;
        end
        default: begin
          idle_pct = 22;
          stall_pct = 22;
        end
      endcase
      for (int k = 0; k < SECTORS_PER_PHASE; k++) random_run();
    end

    sector_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mptd_pkg.sv
hdl/mptd_front.sv
hdl/mptd_queue.sv
hdl/mptd_back.sv
hdl/mbr_partition_table_decoder_unit.sv
hdl/mptd_checker.sv
test/mbr_record_checker.sv
test/tb_mbr_partition_table_decoder_unit.sv
